@@ src/u8dec_pkg.sv @@
// Package for the UTF-8 decoder: code point constants, queue sizing,
// the queue entry type and the scalar value check.
// No dependencies; used by every module of the decoder.
`default_nettype none

package u8dec_pkg;

    localparam int unsigned CP_W   = 21;
    localparam int unsigned QDEPTH = 4;               // power of two, pointers wrap
    localparam int unsigned QAW    = $clog2(QDEPTH);

    localparam logic [CP_W-1:0] REPLACEMENT = 21'd65533;
    localparam logic [CP_W-1:0] MAX_SCALAR  = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO     = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI     = 21'h00DFFF;
    localparam logic [CP_W-1:0] MIN_LEN2    = 21'h000080;
    localparam logic [CP_W-1:0] MIN_LEN3    = 21'h000800;
    localparam logic [CP_W-1:0] MIN_LEN4    = 21'h010000;

    localparam logic [1:0] CLS_NONE = 2'd0;
    localparam logic [1:0] CLS_LEN2 = 2'd1;
    localparam logic [1:0] CLS_LEN3 = 2'd2;
    localparam logic [1:0] CLS_LEN4 = 2'd3;

    // One queue entry holds all results of one byte. When two is set the
    // first result is always U+FFFD and cp is the second one.
    typedef struct packed {
        logic            two;
        logic [CP_W-1:0] cp;
    } t_entry;

    // Replace overlong forms, values past the last scalar and surrogates.
    function automatic logic [CP_W-1:0] check_value(input logic [CP_W-1:0] v,
                                                     input logic [1:0]      cls);
        logic [CP_W-1:0] vmin;
        case (cls)
            CLS_LEN2: vmin = MIN_LEN2;
            CLS_LEN3: vmin = MIN_LEN3;
            CLS_LEN4: vmin = MIN_LEN4;
            default:  vmin = '0;
        endcase
        if (v < vmin || v > MAX_SCALAR || (v >= SURR_LO && v <= SURR_HI)) begin
            return REPLACEMENT;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

@@ src/utf8_decoder_with_replacement.sv @@
// UTF-8 decoder with U+FFFD replacement. A code point passes through the queue
// and then the output register to the master side after its byte is accepted.
// Throughput: one byte per cycle while the queue has room, one code point per
// cycle while m_axis_tready is high; a byte that yields two code points uses two transfers.
// Reset (i_rst_n low, synchronous): no sequence open, queue empty, output idle.
// Depends on u8dec_pkg, u8dec_front, u8dec_fifo, u8dec_back.
`default_nettype none

module utf8_decoder_with_replacement (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // byte request in
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] byte_in
    input  wire logic        s_axis_tlast,   // end_of_text
    // code point out
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [20:0] code_point, [23:21] zero
    output logic             m_axis_tlast    // run_last
);
    import u8dec_pkg::*;

    logic            q_ready;
    logic            q_push;
    t_entry          q_in;
    logic            q_pop;
    logic            q_nonempty;
    t_entry          q_out;
    logic [CP_W-1:0] out_cp;

    // Front: classify the byte, advance the sequence state, push its results.
    u8dec_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tvalid  (s_axis_tvalid),
        .i_byte    (s_axis_tdata),
        .i_eot     (s_axis_tlast),
        .i_q_ready (q_ready),
        .o_tready  (s_axis_tready),
        .o_push    (q_push),
        .o_entry   (q_in)
    );

    // Queue: lets the front keep accepting while the output stalls.
    u8dec_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_entry    (q_in),
        .i_pop      (q_pop),
        .o_ready    (q_ready),
        .o_nonempty (q_nonempty),
        .o_entry    (q_out)
    );

    // Back: hold each code point in the output register until taken.
    u8dec_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_nonempty (q_nonempty),
        .i_q_entry    (q_out),
        .o_q_pop      (q_pop),
        .i_tready     (m_axis_tready),
        .o_tvalid     (m_axis_tvalid),
        .o_cp         (out_cp),
        .o_last       (m_axis_tlast)
    );

    assign m_axis_tdata = {3'b000, out_cp};

endmodule

`default_nettype wire

@@ src/u8dec_front.sv @@
// Front end of the UTF-8 decoder: holds the sequence state, classifies
// each byte and pushes the results it causes into the queue as one entry.
// Depends on u8dec_pkg.
`default_nettype none

module u8dec_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_tvalid,
    input  wire logic [7:0]        i_byte,
    input  wire logic              i_eot,
    input  wire logic              i_q_ready,
    output logic                   o_tready,
    output logic                   o_push,
    output u8dec_pkg::t_entry      o_entry
);
    import u8dec_pkg::*;

    logic [1:0]      r_pend, n_pend;
    logic [CP_W-1:0] r_val,  n_val;
    logic [1:0]      r_cls,  n_cls;

    logic            got;
    logic            two;
    logic [CP_W-1:0] cp;
    logic            restart;
    logic [CP_W-1:0] joined;
    logic            accept;

    assign o_tready = i_q_ready;
    assign accept   = i_tvalid && i_q_ready;
    assign joined   = {r_val[CP_W-7:0], i_byte[5:0]};

    always_comb begin
        n_pend  = r_pend;
        n_val   = r_val;
        n_cls   = r_cls;
        got     = 1'b0;
        two     = 1'b0;
        cp      = '0;
        restart = 1'b0;

        if (r_pend != 2'd0) begin
            if (i_byte[7:6] == 2'b10) begin
                n_val  = joined;
                n_pend = r_pend - 2'd1;
                if (r_pend == 2'd1) begin
                    got    = 1'b1;
                    cp     = check_value(joined, r_cls);
                    n_pend = 2'd0;
                    n_val  = '0;
                    n_cls  = CLS_NONE;
                end
            end else begin
                // missing continuation: close the open sequence, rescan the byte
                got     = 1'b1;
                cp      = REPLACEMENT;
                n_pend  = 2'd0;
                n_val   = '0;
                n_cls   = CLS_NONE;
                restart = 1'b1;
            end
        end else begin
            restart = 1'b1;
        end

        if (restart) begin
            if (i_byte < 8'h80) begin
                two = got;
                got = 1'b1;
                cp  = {13'd0, i_byte};
            end else if (i_byte >= 8'hC2 && i_byte <= 8'hDF) begin
                n_val  = {16'd0, i_byte[4:0]};
                n_pend = 2'd1;
                n_cls  = CLS_LEN2;
            end else if (i_byte >= 8'hE0 && i_byte <= 8'hEF) begin
                n_val  = {17'd0, i_byte[3:0]};
                n_pend = 2'd2;
                n_cls  = CLS_LEN3;
            end else if (i_byte >= 8'hF0 && i_byte <= 8'hF4) begin
                n_val  = {18'd0, i_byte[2:0]};
                n_pend = 2'd3;
                n_cls  = CLS_LEN4;
            end else begin
                two = got;
                got = 1'b1;
                cp  = REPLACEMENT;
            end
        end

        if (i_eot) begin
            // cut-off sequence at end of text
            if (n_pend != 2'd0) begin
                two = got;
                got = 1'b1;
                cp  = REPLACEMENT;
            end
            n_pend = 2'd0;
            n_val  = '0;
            n_cls  = CLS_NONE;
        end
    end

    assign o_push      = accept && got;
    assign o_entry.two = two;
    assign o_entry.cp  = cp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 2'd0;
            r_val  <= '0;
            r_cls  <= CLS_NONE;
        end else if (accept) begin
            r_pend <= n_pend;
            r_val  <= n_val;
            r_cls  <= n_cls;
        end
    end

endmodule

`default_nettype wire

@@ src/u8dec_fifo.sv @@
// Short queue of result entries between the front and back ends of the
// UTF-8 decoder. Depends on u8dec_pkg for the entry type and depth.
`default_nettype none

module u8dec_fifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  u8dec_pkg::t_entry      i_entry,
    input  wire logic              i_pop,
    output logic                   o_ready,
    output logic                   o_nonempty,
    output u8dec_pkg::t_entry      o_entry
);
    import u8dec_pkg::*;

    t_entry         r_mem [QDEPTH];
    logic [QAW-1:0] r_wr;
    logic [QAW-1:0] r_rd;
    logic [QAW:0]   r_cnt;

    assign o_ready    = (r_cnt != QDEPTH[QAW:0]);
    assign o_nonempty = (r_cnt != '0);
    assign o_entry    = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ src/u8dec_back.sv @@
// Back end of the UTF-8 decoder: drains queue entries into the output
// register, splitting an entry of two results over two transfers.
// Depends on u8dec_pkg.
`default_nettype none

module u8dec_back (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_q_nonempty,
    input  u8dec_pkg::t_entry            i_q_entry,
    output logic                         o_q_pop,
    input  wire logic                    i_tready,
    output logic                         o_tvalid,
    output logic [u8dec_pkg::CP_W-1:0]   o_cp,
    output logic                         o_last
);
    import u8dec_pkg::*;

    logic            r_valid;
    logic [CP_W-1:0] r_cp;
    logic            r_last;
    logic            r_pend;
    logic [CP_W-1:0] r_pend_cp;
    logic            load;

    assign load    = !r_valid || i_tready;
    assign o_q_pop = load && !r_pend && i_q_nonempty;

    assign o_tvalid = r_valid;
    assign o_cp     = r_cp;
    assign o_last   = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else if (load) begin
            if (r_pend) begin
                // second half of a pair
                r_valid <= 1'b1;
                r_pend  <= 1'b0;
            end else if (i_q_nonempty) begin
                r_valid <= 1'b1;
                r_pend  <= i_q_entry.two;
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_pend) begin
                r_cp   <= r_pend_cp;
                r_last <= 1'b1;
            end else if (i_q_entry.two) begin
                r_cp      <= REPLACEMENT;
                r_last    <= 1'b0;
                r_pend_cp <= i_q_entry.cp;
            end else begin
                r_cp   <= i_q_entry.cp;
                r_last <= 1'b1;
            end
        end
    end

endmodule

`default_nettype wire
